// ----- hdl/sti_pkg.sv -----
// ---------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the symbol table intern unit.
// ---------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

  localparam int CHAR_W    = 7;
  localparam int IN_CHARS  = 8;
  localparam int KEY_W     = CHAR_W * IN_CHARS;
  localparam int LEN_W     = 4;
  localparam int OUT_IDX_W = 8;
  localparam int MAIN_CHARS = 4;

  typedef logic [CHAR_W-1:0] char_t;

  // one-character marker that stands for the main entry
  localparam char_t MARKER_CHAR = 7'h1D;

  // "MAIN", first character first
  localparam char_t MAIN_NAME [MAIN_CHARS] = '{7'h4D, 7'h41, 7'h49, 7'h4E};

  // request moving down the cell chain
  typedef struct packed {
    logic             vld;
    logic             done;
    logic             ins;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } tok_t;

endpackage

`default_nettype wire

// ----- hdl/sti_front.sv -----
// ---------------------------------------------------------------------------
// sti_front
// Input stage: clamps the length to 1..NAME_CHARS, clears unused characters,
// swaps the main marker for MAIN and registers the request for the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module sti_front
  import sti_pkg::*;
#(
  parameter int NAME_CHARS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [KEY_W-1:0] in_chars,
  input  wire logic [LEN_W-1:0] in_len,
  output tok_t                  tok_o
);

  localparam logic [LEN_W:0] NC       = (LEN_W+1)'(NAME_CHARS);
  localparam int             MAIN_LEN = (NAME_CHARS < MAIN_CHARS) ? NAME_CHARS : MAIN_CHARS;

  logic [LEN_W:0]   len5;
  logic [KEY_W-1:0] key;
  logic [LEN_W-1:0] len;
  tok_t             tok_r;

  always_comb begin
    len5 = {1'b0, in_len};
    if (len5 == '0) begin
      len5 = (LEN_W+1)'(1);
    end
    if (len5 > NC) begin
      len5 = NC;
    end
    key = '0;
    for (int c = 0; c < IN_CHARS; c++) begin
      if ((LEN_W+1)'(c) < len5) begin
        key[c*CHAR_W +: CHAR_W] = in_chars[c*CHAR_W +: CHAR_W];
      end
    end
    len = len5[LEN_W-1:0];
    // main marker becomes MAIN, cut to the name width
    if (len5 == (LEN_W+1)'(1) && key[CHAR_W-1:0] == MARKER_CHAR) begin
      key = '0;
      for (int c = 0; c < MAIN_LEN; c++) begin
        key[c*CHAR_W +: CHAR_W] = MAIN_NAME[c];
      end
      len = LEN_W'(MAIN_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r.vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.done <= 1'b0;
      tok_r.ins  <= 1'b0;
      tok_r.key  <= key;
      tok_r.len  <= len;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ----- hdl/sti_cell.sv -----
// ---------------------------------------------------------------------------
// sti_cell
// One table entry. Compares the passing request against its entry, claims
// an unresolved request on a hit, or takes the name if the entry is free.
// ---------------------------------------------------------------------------
`default_nettype none

module sti_cell
  import sti_pkg::*;
#(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire tok_t             tok_i,
  input  wire logic [IDX_W-1:0] idx_i,
  output tok_t                  tok_o,
  output logic      [IDX_W-1:0] idx_o,
  output logic                  ent_vld_o
);

  logic             ent_vld_r;
  logic [KEY_W-1:0] ent_key_r;
  logic [LEN_W-1:0] ent_len_r;
  tok_t             tok_r;
  logic [IDX_W-1:0] idx_r;
  logic             open_req;
  logic             match;
  logic             take;
  tok_t             tok_nxt;
  logic [IDX_W-1:0] idx_nxt;

  assign open_req = tok_i.vld && !tok_i.done;
  assign match    = ent_vld_r && ent_key_r == tok_i.key && ent_len_r == tok_i.len;
  // entries fill from index 0, so the first free entry ends the search
  assign take     = open_req && !ent_vld_r;

  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (open_req && (match || !ent_vld_r)) begin
      tok_nxt.done = 1'b1;
      tok_nxt.ins  = !ent_vld_r;
      idx_nxt      = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r.vld <= tok_nxt.vld;
      if (take) begin
        ent_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.done <= tok_nxt.done;
      tok_r.ins  <= tok_nxt.ins;
      tok_r.key  <= tok_nxt.key;
      tok_r.len  <= tok_nxt.len;
      idx_r      <= idx_nxt;
      if (take) begin
        ent_key_r <= tok_i.key;
        ent_len_r <= tok_i.len;
      end
    end
  end

  assign tok_o     = tok_r;
  assign idx_o     = idx_r;
  assign ent_vld_o = ent_vld_r;

endmodule

`default_nettype wire

// ----- hdl/symbol_table_intern_unit.sv -----
// ---------------------------------------------------------------------------
// symbol_table_intern_unit
// Lookup-or-insert symbol table built as a chain of entry cells.
// ---------------------------------------------------------------------------
// Each request walks a chain of TABLE_DEPTH cells, one cell per cycle, and is
// registered in the front stage, each cell and the output. Unless stalled,
// requests follow each other in every cycle, so one request per cycle is
// sustained; a request always sees the entries that earlier requests have
// added. A stall on the result side freezes the whole chain. A hit returns
// the stored index, a miss takes the first free entry and sets inserted,
// and a miss on a full table stores nothing and sets table_full with index
// zero. A one-character name 0x1D is looked up as MAIN. Entries are held in
// the cells and are never removed; reset empties the table at once.
`default_nettype none

module symbol_table_intern_unit
  import sti_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int NAME_CHARS  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [KEY_W-1:0]     in_name_chars,
  input  wire logic [LEN_W-1:0]     in_name_length,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [OUT_IDX_W-1:0] out_entry_index,
  output logic                      out_inserted,
  output logic                      out_table_full
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                 en;
  tok_t                 tok   [TABLE_DEPTH+1];
  logic [IDX_W-1:0]     idx   [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] ent_vld;
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_index_r;
  logic                 out_ins_r;
  logic                 out_full_r;

  // whole chain moves unless a finished result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  sti_front #(
    .NAME_CHARS(NAME_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_chars(in_name_chars),
    .in_len  (in_name_length),
    .tok_o   (tok[0])
  );

  assign idx[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sti_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .tok_i    (tok[i]),
      .idx_i    (idx[i]),
      .tok_o    (tok[i+1]),
      .idx_o    (idx[i+1]),
      .ent_vld_o(ent_vld[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tok[TABLE_DEPTH].vld;
    end
  end

  // a request still open at the end of the chain found no free entry
  always_ff @(posedge clk) begin
    if (en) begin
      out_index_r <= tok[TABLE_DEPTH].done ? OUT_IDX_W'(idx[TABLE_DEPTH]) : '0;
      out_ins_r   <= tok[TABLE_DEPTH].done && tok[TABLE_DEPTH].ins;
      out_full_r  <= !tok[TABLE_DEPTH].done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_index_r;
  assign out_inserted    = out_ins_r;
  assign out_table_full  = out_full_r;

  // entries always form an unbroken run from index zero
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((ent_vld + TABLE_DEPTH'(1)) & ent_vld) == '0)
    else $error("table entries not filled in order");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (&ent_vld && !out_inserted))
    else $error("table_full reported with free entries or with inserted");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_entry_index == '0))
    else $error("table_full result carries a nonzero index");

endmodule

`default_nettype wire

// ----- test/sti_checker.sv -----
// ---------------------------------------------------------------------------
// sti_checker
// Watches both channels of the symbol table intern unit, keeps its own copy
// of the table, predicts each result and compares it with what comes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sti_checker
  import sti_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int NAME_CHARS  = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [KEY_W-1:0]     in_name_chars,
  input  wire logic [LEN_W-1:0]     in_name_length,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [OUT_IDX_W-1:0] out_entry_index,
  input  wire logic                 out_inserted,
  input  wire logic                 out_table_full,
  output int                        n_errors,
  output int                        n_pending,
  output int                        n_hits,
  output int                        n_inserts,
  output int                        n_full
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 inserted;
    logic                 table_full;
  } intern_result_t;

  logic [KEY_W-1:0] known_names   [TABLE_DEPTH];
  logic [LEN_W-1:0] known_lengths [TABLE_DEPTH];
  int               known_count;

  intern_result_t   expected_results [$];

  // lookup-or-insert against the shadow table
  function automatic intern_result_t intern_name(input logic [KEY_W-1:0] chars,
                                                 input logic [LEN_W-1:0] raw_len);
    int               len;
    int               found;
    int               n;
    logic [KEY_W-1:0] key;
    intern_result_t   res;
    len = raw_len;
    if (len < 1) len = 1;
    if (len > NAME_CHARS) len = NAME_CHARS;
    if (len >= IN_CHARS) key = chars;
    else key = chars & ((KEY_W'(1) << (CHAR_W * len)) - KEY_W'(1));

    if (len == 1 && key[CHAR_W-1:0] == MARKER_CHAR) begin
      n = (MAIN_CHARS < NAME_CHARS) ? MAIN_CHARS : NAME_CHARS;
      key = '0;
      for (int i = 0; i < n; i++) key[CHAR_W*i +: CHAR_W] = MAIN_NAME[i];
      len = n;
    end

    // newest entry wins, though duplicates cannot arise
    found = -1;
    for (int k = known_count - 1; k >= 0; k--) begin
      if (found < 0 && known_lengths[k] == LEN_W'(len) && known_names[k] == key)
        found = k;
    end

    if (found >= 0) begin
      res = '{entry_index: OUT_IDX_W'(found), inserted: 1'b0, table_full: 1'b0};
      n_hits++;
    end else if (known_count < TABLE_DEPTH) begin
      known_names[known_count]   = key;
      known_lengths[known_count] = LEN_W'(len);
      res = '{entry_index: OUT_IDX_W'(known_count), inserted: 1'b1, table_full: 1'b0};
      known_count++;
      n_inserts++;
    end else begin
      res = '{entry_index: '0, inserted: 1'b0, table_full: 1'b1};
      n_full++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    intern_result_t want;
    intern_result_t got;
    if (!rst_n) begin
      known_count = 0;
      expected_results.delete();
      n_errors  <= 0;
      n_hits    = 0;
      n_inserts = 0;
      n_full    = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(intern_name(in_name_chars, in_name_length));

      if (out_valid && !out_stall) begin
        got = '{entry_index: out_entry_index, inserted: out_inserted,
                table_full: out_table_full};
        if (expected_results.size() == 0) begin
          n_errors <= n_errors + 1;
          $display("%0t: unexpected result, expected none, got index %0d ins %b full %b",
                   $time, got.entry_index, got.inserted, got.table_full);
        end else begin
          want = expected_results.pop_front();
          if (got.entry_index !== want.entry_index || got.inserted !== want.inserted ||
              got.table_full !== want.table_full) begin
            n_errors <= n_errors + 1;
            $display({"%0t: mismatch, expected index %0d ins %b full %b,",
                      " got index %0d ins %b full %b"},
                     $time, want.entry_index, want.inserted, want.table_full,
                     got.entry_index, got.inserted, got.table_full);
          end
        end
      end
    end
    n_pending <= expected_results.size();
  end

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Drives name requests into the symbol table intern unit and gives the
// verdict; a checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sti_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int NAME_CHARS     = 8;
  localparam int LATENCY        = TABLE_DEPTH + 2;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int ITEMS_PER_MIX  = RANDOM_ITEMS / 3;
  localparam int HOLD_AT        = 1000;
  localparam int HOLD_CYCLES    = 3 * TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + LATENCY);

  typedef struct packed {
    logic [KEY_W-1:0] chars;
    logic [LEN_W-1:0] len;
  } name_req_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [KEY_W-1:0]     in_name_chars;
  logic [LEN_W-1:0]     in_name_length;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_IDX_W-1:0] out_entry_index;
  logic                 out_inserted;
  logic                 out_table_full;

  int n_errors, n_pending, n_hits, n_inserts, n_full;
  int tx_idle_pct;
  int rx_idle_pct;
  int requests_sent;
  bit held_off;

  name_req_t sent_names [$];

  symbol_table_intern_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_name_chars  (in_name_chars),
    .in_name_length (in_name_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_entry_index(out_entry_index),
    .out_inserted   (out_inserted),
    .out_table_full (out_table_full)
  );

  sti_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_name_chars  (in_name_chars),
    .in_name_length (in_name_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_entry_index(out_entry_index),
    .out_inserted   (out_inserted),
    .out_table_full (out_table_full),
    .n_errors       (n_errors),
    .n_pending      (n_pending),
    .n_hits         (n_hits),
    .n_inserts      (n_inserts),
    .n_full         (n_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] rand_chars();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  // offer one request, with a random gap first, and hold it until taken
  task automatic send_name(input logic [KEY_W-1:0] chars, input logic [LEN_W-1:0] len);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_name_chars  <= chars;
    in_name_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_names.push_back('{chars: chars, len: len});
    requests_sent++;
  endtask

  // result side: random stalls, plus one long hold-off to back the chain up
  initial begin
    out_stall = 1'b0;
    held_off  = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && requests_sent >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] main_chars;
    logic [KEY_W-1:0] ab_chars;
    logic [KEY_W-1:0] chars;
    logic [LEN_W-1:0] len;
    name_req_t        pick;
    int               eff;
    int               sel;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_name_chars  = '0;
    in_name_length = '0;
    requests_sent  = 0;
    tx_idle_pct    = 31;
    rx_idle_pct    = 51;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    main_chars = '0;
    for (int i = 0; i < MAIN_CHARS; i++) main_chars[CHAR_W*i +: CHAR_W] = MAIN_NAME[i];
    ab_chars = {42'h0, 7'h42, 7'h41};

    // field extremes
    send_name('0, 4'd1);
    send_name('1, 4'd8);
    send_name('1, 4'd8);
    send_name('1, 4'd15);
    send_name('0, 4'd0);
    send_name({KEY_W{1'b1}} << CHAR_W, 4'd0);
    send_name('0, 4'd8);
    send_name('0, 4'd2);
    // main marker and its spelled-out form, with junk above the marker
    send_name(KEY_W'(MARKER_CHAR), 4'd1);
    send_name(main_chars, 4'd4);
    send_name((rand_chars() << CHAR_W) | KEY_W'(MARKER_CHAR), 4'd1);
    send_name(KEY_W'(MARKER_CHAR), 4'd0);
    // marker character but not a one-character name, and a cut-short MAIN
    send_name(KEY_W'(MARKER_CHAR), 4'd2);
    send_name(KEY_W'(MARKER_CHAR), 4'd9);
    send_name(main_chars, 4'd3);
    // characters past the length are ignored
    send_name(ab_chars, 4'd2);
    send_name(ab_chars | (rand_chars() << (2 * CHAR_W)), 4'd2);
    send_name(ab_chars, 4'd3);
    send_name(ab_chars | (rand_chars() << (3 * CHAR_W)), 4'd1);
    send_name(rand_chars(), 4'd7);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / ITEMS_PER_MIX)
        0:       begin tx_idle_pct = 31; rx_idle_pct = 51; end
        1:       begin tx_idle_pct = 51; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase

      pick = sent_names[$urandom_range(0, sent_names.size() - 1)];
      eff  = (pick.len == 0) ? 1 : (pick.len > NAME_CHARS) ? NAME_CHARS : pick.len;
      sel  = $urandom_range(0, 99);
      if (sel < 40) begin
        // same name again, fresh junk past the length, equivalent length code
        chars = pick.chars ^ (rand_chars() << (CHAR_W * eff));
        if (eff == NAME_CHARS) len = LEN_W'($urandom_range(NAME_CHARS, 15));
        else if (eff == 1) len = LEN_W'($urandom_range(0, 1));
        else len = LEN_W'(eff);
      end else if (sel < 50) begin
        // one bit off a known name
        chars = pick.chars ^ (KEY_W'(1) << $urandom_range(0, CHAR_W * eff - 1));
        len   = pick.len;
      end else if (sel < 55) begin
        chars = (rand_chars() << CHAR_W) | KEY_W'(MARKER_CHAR);
        len   = LEN_W'($urandom_range(0, 1));
      end else begin
        chars = rand_chars();
        len   = LEN_W'($urandom_range(0, 15));
      end
      send_name(chars, len);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("covered %0d requests: %0d hits, %0d inserts, %0d misses on a full table",
             requests_sent, n_hits, n_inserts, n_full);
    $display("idle mixes 31/51, 51/31 and none, with one long result-side hold-off");
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
